// ===== src/qmv_pkg.sv =====
`default_nettype none

package qmv_pkg;

  // Default size of the activation store in elements
  localparam int MAX_ELEMENTS_DEF = 4096;

  // Queue depths between front, back and result port
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_ZERO_POINT   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_VECTOR_PAIRS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT    = 2'd2;

  // Register reset values
  localparam logic [7:0]  ZERO_POINT_RST   = 8'h80;
  localparam logic [11:0] VECTOR_PAIRS_RST = 12'd2048;
  localparam logic [15:0] ROW_COUNT_RST    = 16'd1;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_t;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_t               cmd;
    logic               first;
    logic               last_pair;
    logic               final_row;
    logic signed [7:0]  code_even;
    logic signed [7:0]  code_odd;
    logic signed [19:0] row_sum;
  } item_t;

  // Finished row result
  typedef struct packed {
    logic               last_row;
    logic signed [31:0] row_result;
  } res_t;

endpackage

`default_nettype wire

// ===== src/qmv_fifo.sv =====
`default_nettype none

module qmv_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [W-1:0]                 din,
  output logic                              full,
  input  wire logic                         pop,
  output logic [W-1:0]                      dout,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign dout    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== src/qmv_front.sv =====
`default_nettype none

module qmv_front #(
  parameter int MAX_ELEMENTS = qmv_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [11:0]                       vector_pairs,
  input  wire logic [15:0]                       row_count,
  input  wire logic                              accept,
  input  wire qmv_pkg::cmd_t                     command,
  input  wire logic signed [7:0]                 code_even,
  input  wire logic signed [7:0]                 code_odd,
  input  wire logic signed [19:0]                row_sum,
  output logic                                   push,
  output qmv_pkg::item_t                         item,
  output logic [$clog2(MAX_ELEMENTS/2)-1:0]      slot
);

  localparam int PW = $clog2(MAX_ELEMENTS/2);
  localparam int AW = (PW + 1 > 12) ? PW + 1 : 12;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [AW-1:0] pairs_eff;
  logic [AW-1:0] pos_inc;
  logic [15:0]   rows_eff;
  logic          last_pair;
  logic          final_row;

  // effective pair and row counts after clamping
  always_comb begin
    if (vector_pairs == '0) begin
      pairs_eff = AW'(1);
    end else if (AW'(vector_pairs) > AW'(MAX_ELEMENTS/2)) begin
      pairs_eff = AW'(MAX_ELEMENTS/2);
    end else begin
      pairs_eff = AW'(vector_pairs);
    end
    rows_eff = (row_count == '0) ? 16'd1 : row_count;
  end

  // classify the beat against the current positions
  always_comb begin
    pos_inc   = AW'(pos_r) + AW'(1);
    last_pair = (pos_inc >= pairs_eff);
    final_row = ({1'b0, row_r} + 17'd1 >= {1'b0, rows_eff});
    slot      = (AW'(pos_r) < pairs_eff) ? pos_r : PW'(pairs_eff - AW'(1));

    item.cmd       = command;
    item.first     = (pos_r == '0);
    item.last_pair = last_pair;
    item.final_row = final_row;
    item.code_even = code_even;
    item.code_odd  = code_odd;
    item.row_sum   = row_sum;
    push           = accept;
  end

  // position update
  always_comb begin
    pos_nxt = pos_r;
    row_nxt = row_r;
    if (accept) begin
      pos_nxt = last_pair ? '0 : PW'(pos_inc);
      if (command == qmv_pkg::CMD_LOAD) begin
        row_nxt = '0;
      end else if (last_pair) begin
        row_nxt = final_row ? '0 : row_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      row_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/qmv_back.sv =====
`default_nettype none

module qmv_back #(
  parameter int MAX_ELEMENTS = qmv_pkg::MAX_ELEMENTS_DEF,
  parameter int OUT_DEPTH    = qmv_pkg::OUT_DEPTH
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic [7:0]                                       zero_point,
  input  wire logic                                             mid_empty,
  input  wire logic [$bits(qmv_pkg::item_t)+$clog2(MAX_ELEMENTS/2)-1:0] mid_data,
  output logic                                                  mid_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]                   out_count,
  output logic                                                  out_push,
  output qmv_pkg::res_t                                         out_data
);

  localparam int PW    = $clog2(MAX_ELEMENTS/2);
  localparam int IW    = $bits(qmv_pkg::item_t);
  localparam int DEPTH = MAX_ELEMENTS/2;
  localparam int CW    = $clog2(OUT_DEPTH+1);
  localparam int UW    = CW + 1;

  qmv_pkg::item_t head;
  logic [PW-1:0]  head_slot;

  // activation store, one pair of bytes per word
  logic [15:0] act_mem [DEPTH];

  // stage registers
  logic                v1_r, v2_r, v3_r, v4_r;
  qmv_pkg::item_t      it1_r, it2_r, it3_r;
  logic [15:0]         rd_r;
  logic signed [16:0]  p0_2_r, p1_2_r;
  logic signed [28:0]  corr2_r, corr3_r, corr4_r;
  logic signed [15:0]  pair3_r;
  logic [31:0]         sum4_r;
  logic                final4_r;
  logic signed [19:0]  held_r, held_nxt;
  logic [31:0]         acc_r, acc_nxt;

  logic signed [16:0]  p0, p1;
  logic signed [28:0]  corr;
  logic signed [17:0]  pair_sum;
  logic signed [15:0]  pair_sat;
  logic [31:0]         sum;
  logic                res1, res2, res3;
  logic [2:0]          inflight;
  logic [UW-1:0]       used;

  assign head      = qmv_pkg::item_t'(mid_data[IW-1:0]);
  assign head_slot = mid_data[IW +: PW];

  // pop only while every result in flight has a place in the result queue
  always_comb begin
    res1     = v1_r && (it1_r.cmd == qmv_pkg::CMD_WEIGHT) && it1_r.last_pair;
    res2     = v2_r && (it2_r.cmd == qmv_pkg::CMD_WEIGHT) && it2_r.last_pair;
    res3     = v3_r && (it3_r.cmd == qmv_pkg::CMD_WEIGHT) && it3_r.last_pair;
    inflight = 3'(res1) + 3'(res2) + 3'(res3) + 3'(v4_r);
    used     = UW'(out_count) + UW'(inflight);
    mid_pop  = !mid_empty && (used < UW'(OUT_DEPTH));
  end

  // stage 0: store write for loads, registered read for weights
  always_ff @(posedge clk) begin
    if (mid_pop) begin
      if (head.cmd == qmv_pkg::CMD_LOAD) begin
        act_mem[head_slot] <= {8'(head.code_odd) + zero_point,
                               8'(head.code_even) + zero_point};
      end
      rd_r <= act_mem[head_slot];
    end
  end

  // stage 1: byte products and row correction
  always_comb begin
    p0       = $signed({1'b0, rd_r[7:0]}) * it1_r.code_even;
    p1       = $signed({1'b0, rd_r[15:8]}) * it1_r.code_odd;
    held_nxt = held_r;
    if (v1_r && (it1_r.cmd == qmv_pkg::CMD_WEIGHT) && it1_r.first) begin
      held_nxt = it1_r.row_sum;
    end
    corr = $signed({1'b0, zero_point}) * held_nxt;
  end

  // stage 2: pair sum saturated to 16 bits
  always_comb begin
    pair_sum = 18'(p0_2_r) + 18'(p1_2_r);
    if (pair_sum > 18'sd32767) begin
      pair_sat = 16'sh7fff;
    end else if (pair_sum < -18'sd32768) begin
      pair_sat = -16'sh8000;
    end else begin
      pair_sat = 16'(pair_sum);
    end
  end

  // stage 3: accumulate, loads restart the sum
  always_comb begin
    sum     = (it3_r.first ? 32'd0 : acc_r) + {{16{pair3_r[15]}}, pair3_r};
    acc_nxt = acc_r;
    if (v3_r) begin
      if (it3_r.cmd == qmv_pkg::CMD_LOAD) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = it3_r.last_pair ? 32'd0 : sum;
      end
    end
  end

  // stage 4: apply correction and queue the result
  always_comb begin
    out_push            = v4_r;
    out_data.last_row   = final4_r;
    out_data.row_result = $signed(sum4_r - {{3{corr4_r[28]}}, corr4_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      held_r <= '0;
      acc_r  <= '0;
    end else begin
      v1_r   <= mid_pop;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= res3;
      held_r <= held_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    it1_r    <= head;
    it2_r    <= it1_r;
    it3_r    <= it2_r;
    p0_2_r   <= p0;
    p1_2_r   <= p1;
    corr2_r  <= corr;
    corr3_r  <= corr2_r;
    pair3_r  <= pair_sat;
    corr4_r  <= corr3_r;
    sum4_r   <= sum;
    final4_r <= it3_r.final_row;
  end

endmodule

`default_nettype wire

// ===== src/quantized_matvec_pair_saturating.sv =====
// Int8 matrix-vector product with a zero point, two elements per beat.
// Input queue side: in_push / in_full. A load beat (command 0) stores two
// activation codes shifted by zero_point; a weight beat (command 1) brings two
// weight codes of the current row, with the row's code sum on the first pair.
// Result queue side: out_empty / out_pop. One result per finished row: the
// accumulated saturated pair products minus zero_point times the row sum,
// with last_row set on the final row of the matrix.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
// write only while no beat is in flight.
// Throughput: one beat per cycle while in_full is low and the back end is not
// holding beats, set by a single pass of each beat through the back-end
// pipeline (store read, multiply, saturate, accumulate, correct).
// A short queue separates the classifying front end from the back end. When
// the receiver stops popping, the back end holds beats once the result queue
// has no room for results in flight, and in_full rises as the middle queue
// fills; nothing is dropped.
// Reset clears positions, accumulator, queues and registers to their reset
// values; the activation store is not cleared and must be loaded before use.
`default_nettype none

module quantized_matvec_pair_saturating #(
  parameter int MAX_ELEMENTS = qmv_pkg::MAX_ELEMENTS_DEF,
  parameter int MID_DEPTH    = qmv_pkg::MID_DEPTH,
  parameter int OUT_DEPTH    = qmv_pkg::OUT_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_command,
  input  wire logic signed [7:0]             in_code_even,
  input  wire logic signed [7:0]             in_code_odd,
  input  wire logic signed [19:0]            in_row_sum,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic signed [31:0]                 out_row_result,
  output logic                               out_last_row,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [qmv_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [qmv_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int PW = $clog2(MAX_ELEMENTS/2);
  localparam int IW = $bits(qmv_pkg::item_t);
  localparam int MW = IW + PW;
  localparam int RW = $bits(qmv_pkg::res_t);

  logic [7:0]     zero_point_r;
  logic [11:0]    vector_pairs_r;
  logic [15:0]    row_count_r;

  logic           accept;
  logic           fr_push;
  qmv_pkg::item_t fr_item;
  logic [PW-1:0]  fr_slot;

  logic           mid_full, mid_empty, mid_pop;
  logic [MW-1:0]  mid_dout;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

  logic           bk_push;
  qmv_pkg::res_t  bk_res;
  qmv_pkg::res_t  out_head;
  logic [RW-1:0]  out_dout;
  logic           out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_point_r   <= qmv_pkg::ZERO_POINT_RST;
      vector_pairs_r <= qmv_pkg::VECTOR_PAIRS_RST;
      row_count_r    <= qmv_pkg::ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qmv_pkg::CFG_ZERO_POINT:   zero_point_r   <= cfg_data[7:0];
        qmv_pkg::CFG_VECTOR_PAIRS: vector_pairs_r <= cfg_data[11:0];
        qmv_pkg::CFG_ROW_COUNT:    row_count_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front end: take beats and classify them
  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  qmv_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .vector_pairs (vector_pairs_r),
    .row_count    (row_count_r),
    .accept       (accept),
    .command      (qmv_pkg::cmd_t'(in_command)),
    .code_even    (in_code_even),
    .code_odd     (in_code_odd),
    .row_sum      (in_row_sum),
    .push         (fr_push),
    .item         (fr_item),
    .slot         (fr_slot)
  );

  // queue between front and back
  qmv_fifo #(
    .W     (MW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .din   ({fr_slot, fr_item}),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count (mid_count)
  );

  // back end: store, multiply, accumulate
  qmv_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .zero_point (zero_point_r),
    .mid_empty  (mid_empty || (mid_count == '0)),
    .mid_data   (mid_dout),
    .mid_pop    (mid_pop),
    .out_count  (out_count),
    .out_push   (bk_push),
    .out_data   (bk_res)
  );

  // result queue
  qmv_fifo #(
    .W     (RW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push && !out_full),
    .din   (bk_res),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_head       = qmv_pkg::res_t'(out_dout);
  assign out_row_result = out_head.row_result;
  assign out_last_row   = out_head.last_row;

endmodule

`default_nettype wire

// ===== tb/sv/quantized_matvec_pair_saturating_test.sv =====
`default_nettype none

module quantized_matvec_pair_saturating_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_EL       = qmv_pkg::MAX_ELEMENTS_DEF;
  localparam int SETTLE       = 12;   // margin for the pipe to empty after the last row
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 750;
  localparam int MIN_ROWS     = 48;

  // Directed plan: either a data beat or a register write
  typedef enum logic {STEP_BEAT, STEP_REG} step_kind_t;

  typedef struct packed {
    step_kind_t                  kind;
    qmv_pkg::cmd_t               cmd;
    logic signed [7:0]           code_even;
    logic signed [7:0]           code_odd;
    logic signed [19:0]          row_sum;
    logic [qmv_pkg::CFG_IW-1:0]  reg_index;
    logic [qmv_pkg::CFG_DW-1:0]  reg_value;
    logic                        typed;
    qmv_pkg::res_t               want;
  } step_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_push = 1'b0;
  logic                        in_full;
  logic                        in_command = 1'b0;
  logic signed [7:0]           in_code_even = '0;
  logic signed [7:0]           in_code_odd = '0;
  logic signed [19:0]          in_row_sum = '0;
  logic                        out_empty;
  logic                        out_pop = 1'b0;
  logic signed [31:0]          out_row_result;
  logic                        out_last_row;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [qmv_pkg::CFG_IW-1:0]  cfg_index = '0;
  logic [qmv_pkg::CFG_DW-1:0]  cfg_data = '0;

  quantized_matvec_pair_saturating u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_code_even   (in_code_even),
    .in_code_odd    (in_code_odd),
    .in_row_sum     (in_row_sum),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_row_result (out_row_result),
    .out_last_row   (out_last_row),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predictor state: activation bytes, positions, accumulator, registers
  logic [7:0]         act_mem [MAX_EL];
  bit                 act_loaded [MAX_EL];
  logic [10:0]        pair_pos = '0;
  logic [15:0]        row_pos = '0;
  logic [31:0]        dot_acc = '0;
  logic signed [19:0] held_sum = '0;
  logic [7:0]         zp_reg = qmv_pkg::ZERO_POINT_RST;
  logic [11:0]        vp_reg = qmv_pkg::VECTOR_PAIRS_RST;
  logic [15:0]        rc_reg = qmv_pkg::ROW_COUNT_RST;

  qmv_pkg::res_t rows_due [$];
  step_t         plan [$];
  int            fault_count = 0;
  int            rows_seen = 0;
  int            random_beats = 0;
  bit            hold_request = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic note_fault(input string msg);
    fault_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int eff_pairs();
    int p;
    p = int'(vp_reg);
    if (p == 0) p = 1;
    if (p > MAX_EL / 2) p = MAX_EL / 2;
    return p;
  endfunction

  function automatic int eff_rows();
    return (rc_reg == 16'd0) ? 1 : int'(rc_reg);
  endfunction

  // Element index that the next beat touches
  function automatic int next_elem();
    int pairs;
    int pos;
    pairs = eff_pairs();
    pos = int'(pair_pos);
    return (((pos < pairs) ? pos : pairs - 1) * 2) % MAX_EL;
  endfunction

  // Advance the predictor by one beat; returns 1 when a row finishes
  function automatic bit predict_beat(input qmv_pkg::cmd_t cmd,
                                      input logic signed [7:0] ce,
                                      input logic signed [7:0] co,
                                      input logic signed [19:0] rs,
                                      output qmv_pkg::res_t row_out);
    int pairs, rows, pos, e0, e1, w0, w1, a0, a1, prod, hs, z, rp;
    bit last_pair, final_row;
    logic [31:0] acc, corr;
    pairs = eff_pairs();
    rows = eff_rows();
    pos = int'(pair_pos);
    last_pair = (pos + 1 >= pairs);
    e0 = next_elem();
    e1 = (e0 + 1) % MAX_EL;
    row_out = '0;
    if (cmd == qmv_pkg::CMD_LOAD) begin
      act_mem[e0] = ce + zp_reg;
      act_mem[e1] = co + zp_reg;
      act_loaded[e0] = 1'b1;
      act_loaded[e1] = 1'b1;
      pair_pos = last_pair ? '0 : 11'(pos + 1);
      row_pos = '0;
      dot_acc = '0;
      return 1'b0;
    end
    w0 = int'(ce);
    w1 = int'(co);
    a0 = int'(act_mem[e0]);
    a1 = int'(act_mem[e1]);
    prod = a0 * w0 + a1 * w1;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    if (pos == 0) begin
      held_sum = rs;
      acc = '0;
    end else begin
      acc = dot_acc;
    end
    acc = acc + 32'(prod);
    dot_acc = acc;
    pair_pos = last_pair ? '0 : 11'(pos + 1);
    if (!last_pair) return 1'b0;
    hs = int'(held_sum);
    z = int'(zp_reg);
    corr = 32'(z * hs);
    rp = int'(row_pos);
    final_row = (rp + 1 >= rows);
    row_out.row_result = acc - corr;
    row_out.last_row = final_row;
    row_pos = final_row ? '0 : 16'(rp + 1);
    dot_acc = '0;
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic logic signed [7:0] pick_code();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return 8'sh80;
    if (r == 1) return 8'sh7F;
    return 8'($urandom);
  endfunction

  function automatic logic signed [19:0] pick_sum();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return 20'sh80000;
    if (r == 1) return 20'sh7F000;
    return 20'($urandom);
  endfunction

  // Register write; cfg_valid is lowered by the caller after the batch
  task automatic write_reg(input logic [qmv_pkg::CFG_IW-1:0] idx,
                           input logic [qmv_pkg::CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      qmv_pkg::CFG_ZERO_POINT:   zp_reg = val[7:0];
      qmv_pkg::CFG_VECTOR_PAIRS: vp_reg = val[11:0];
      qmv_pkg::CFG_ROW_COUNT:    rc_reg = val[15:0];
      default: ;
    endcase
  endtask

  // Stop sending, let every expected row arrive and the pipe empty
  task automatic drain_block();
    in_push <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_beat(input qmv_pkg::cmd_t cmd, input logic signed [7:0] ce,
                           input logic signed [7:0] co, input logic signed [19:0] rs,
                           input bit typed, input qmv_pkg::res_t want, input int gap);
    qmv_pkg::res_t got;
    in_push      <= 1'b1;
    in_command   <= cmd;
    in_code_even <= ce;
    in_code_odd  <= co;
    in_row_sum   <= rs;
    do @(posedge clk); while (in_full);
    if (predict_beat(cmd, ce, co, rs, got)) rows_due.push_back(typed ? want : got);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random beat; a weight that would read a never-loaded entry becomes a load
  task automatic beat_random(input qmv_pkg::cmd_t cmd, input bit counted, input bit eager);
    qmv_pkg::cmd_t c;
    c = cmd;
    if (!eager && $urandom_range(0, 99) < 6)
      c = (cmd == qmv_pkg::CMD_LOAD) ? qmv_pkg::CMD_WEIGHT : qmv_pkg::CMD_LOAD;
    if (c == qmv_pkg::CMD_WEIGHT &&
        !(act_loaded[next_elem()] && act_loaded[next_elem() + 1]))
      c = qmv_pkg::CMD_LOAD;
    push_beat(c, pick_code(), pick_code(), pick_sum(), 1'b0, '0, eager ? 0 : idle_len());
    if (counted) random_beats++;
  endtask

  task automatic run_phase(input bit squeeze);
    int r, pairs, n;
    logic [qmv_pkg::CFG_DW-1:0] v;
    drain_block();
    if (squeeze) begin
      write_reg(qmv_pkg::CFG_VECTOR_PAIRS, 16'd1);
      write_reg(qmv_pkg::CFG_ROW_COUNT, 16'd4);
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        r = int'($urandom_range(0, 9));
        v = (r < 7) ? 16'($urandom_range(64, 128)) : (r == 7) ? 16'd0 :
            (r == 8) ? 16'd255 : 16'($urandom_range(0, 255));
        write_reg(qmv_pkg::CFG_ZERO_POINT, v);
      end
      if ($urandom_range(0, 9) < 6) begin
        r = int'($urandom_range(0, 9));
        v = (r < 8) ? 16'($urandom_range(1, 8)) : (r == 8) ? 16'd0 :
            16'($urandom_range(9, 40));
        write_reg(qmv_pkg::CFG_VECTOR_PAIRS, v);
      end
      if ($urandom_range(0, 9) < 6) begin
        r = int'($urandom_range(0, 9));
        v = (r < 7) ? 16'($urandom_range(1, 5)) : (r == 7) ? 16'd0 :
            (r == 8) ? 16'hFFFF : 16'($urandom_range(6, 20));
        write_reg(qmv_pkg::CFG_ROW_COUNT, v);
      end
    end
    cfg_valid <= 1'b0;
    pairs = eff_pairs();
    if (squeeze) hold_request = 1'b1;
    if (!squeeze && $urandom_range(0, 4) == 0) begin
      // unstructured mix of loads and weights
      n = int'($urandom_range(5, 30));
      repeat (n)
        beat_random(($urandom_range(0, 1) == 1) ? qmv_pkg::CMD_WEIGHT : qmv_pkg::CMD_LOAD,
                    1'b1, 1'b0);
    end else begin
      // full vector load, then whole rows of weights
      repeat (pairs) beat_random(qmv_pkg::CMD_LOAD, 1'b1, squeeze);
      n = squeeze ? 60 : int'($urandom_range(1, 4));
      repeat (n * pairs) beat_random(qmv_pkg::CMD_WEIGHT, 1'b1, squeeze);
    end
  endtask

  function automatic step_t beat_step(input qmv_pkg::cmd_t cmd,
                                      input logic signed [7:0] ce,
                                      input logic signed [7:0] co,
                                      input logic signed [19:0] rs);
    step_t s;
    s = '0;
    s.kind = STEP_BEAT;
    s.cmd = cmd;
    s.code_even = ce;
    s.code_odd = co;
    s.row_sum = rs;
    return s;
  endfunction

  task automatic plan_beat(input qmv_pkg::cmd_t cmd, input logic signed [7:0] ce,
                           input logic signed [7:0] co, input logic signed [19:0] rs);
    plan.push_back(beat_step(cmd, ce, co, rs));
  endtask

  task automatic plan_typed(input qmv_pkg::cmd_t cmd, input logic signed [7:0] ce,
                            input logic signed [7:0] co, input logic signed [19:0] rs,
                            input logic signed [31:0] res, input logic last);
    step_t s;
    s = beat_step(cmd, ce, co, rs);
    s.typed = 1'b1;
    s.want.row_result = res;
    s.want.last_row = last;
    plan.push_back(s);
  endtask

  task automatic plan_reg(input logic [qmv_pkg::CFG_IW-1:0] idx,
                          input logic [qmv_pkg::CFG_DW-1:0] val);
    step_t s;
    s = '0;
    s.kind = STEP_REG;
    s.reg_index = idx;
    s.reg_value = val;
    plan.push_back(s);
  endtask

  // Result side: random pops, one long hold when asked, check every popped row
  initial begin : result_side
    int stall;
    qmv_pkg::res_t exp_row;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        stall = ($urandom_range(0, 9) < 3) ? idle_len() : 0;
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        rows_seen++;
        if (rows_due.size() == 0) begin
          note_fault($sformatf("unexpected row result %0d", out_row_result));
        end else begin
          exp_row = rows_due.pop_front();
          if (out_row_result !== exp_row.row_result)
            note_fault($sformatf("row_result %0d, expected %0d",
                                 out_row_result, exp_row.row_result));
          if (out_last_row !== exp_row.last_row)
            note_fault($sformatf("last_row %0b, expected %0b",
                                 out_last_row, exp_row.last_row));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation and correction extremes with one pair per row, reset zero point
    plan_reg(qmv_pkg::CFG_VECTOR_PAIRS, 16'd1);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sh7F, 8'sh7F, 20'sd0);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sh7F, 8'sh7F, 20'sd0, 32'sd32767, 1'b1);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sh80, 8'sh80, 20'sd0, -32'sd32768, 1'b1);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sd0, 8'sd0, 20'sh80000, 32'sd67108864, 1'b1);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sd0, 8'sd0, 20'sh7FFFF, -32'sd67108736, 1'b1);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sh80, 8'sh80, 20'sd0);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sh7F, 8'sh80, 20'sd5, -32'sd640, 1'b1);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sd1, -8'sd1, -20'sd1, 32'sd128, 1'b1);
    // row count zero behaves as one
    plan_reg(qmv_pkg::CFG_ROW_COUNT, 16'd0);
    plan_typed(qmv_pkg::CMD_WEIGHT, 8'sd5, 8'sd5, 20'sd0, 32'sd0, 1'b1);
    // zero point wraps the shifted code, three rows per matrix
    plan_reg(qmv_pkg::CFG_ZERO_POINT, 16'd255);
    plan_reg(qmv_pkg::CFG_ROW_COUNT, 16'd3);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sd1, 8'sd0, 20'sd0);
    plan_beat(qmv_pkg::CMD_WEIGHT, -8'sd7, 8'sd3, 20'sd100);
    plan_beat(qmv_pkg::CMD_WEIGHT, 8'sd2, 8'sd2, 20'sd0);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sd0, 8'sd0, 20'sd0);
    plan_beat(qmv_pkg::CMD_WEIGHT, 8'sd1, 8'sd1, 20'sd0);
    // position left past the end by a smaller pair count
    plan_reg(qmv_pkg::CFG_VECTOR_PAIRS, 16'd2);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sd10, -8'sd10, 20'sd0);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sd3, 8'sd4, 20'sd0);
    plan_beat(qmv_pkg::CMD_WEIGHT, 8'sd3, 8'sd4, 20'sd7);
    plan_reg(qmv_pkg::CFG_VECTOR_PAIRS, 16'd1);
    plan_beat(qmv_pkg::CMD_WEIGHT, 8'sd1, 8'sd1, 20'sd0);
    // zero point of zero
    plan_reg(qmv_pkg::CFG_ZERO_POINT, 16'd0);
    plan_beat(qmv_pkg::CMD_LOAD, 8'sh80, 8'sh7F, 20'sd0);
    plan_beat(qmv_pkg::CMD_WEIGHT, 8'sh80, 8'sh80, 20'sd0);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        drain_block();
        write_reg(plan[i].reg_index, plan[i].reg_value);
        cfg_valid <= 1'b0;
      end else begin
        push_beat(plan[i].cmd, plan[i].code_even, plan[i].code_odd, plan[i].row_sum,
                  plan[i].typed, plan[i].want, idle_len());
      end
    end

    // random phases, one of them backs the block up
    phase = 0;
    while (random_beats < RANDOM_BEATS || rows_seen < MIN_ROWS) begin
      run_phase(phase == 6);
      phase++;
    end

    drain_block();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/qmv_pkg.sv
src/qmv_fifo.sv
src/qmv_front.sv
src/qmv_back.sv
src/quantized_matvec_pair_saturating.sv
tb/sv/quantized_matvec_pair_saturating_test.sv
